@@ sv/flow_run_period_logger_assert.svh @@
// Assertion macros for the flow run period logger.
// Each macro takes a label, a clock, a reset, a condition and a consequence.
`ifndef FLOW_RUN_PERIOD_LOGGER_ASSERT_SVH
`define FLOW_RUN_PERIOD_LOGGER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define FRPL_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication
`define FRPL_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define FRPL_ASSERT_SAME(label, clk, rst, cond, cons)
`define FRPL_ASSERT_NEXT(label, clk, rst, cond, cons)
`endif

`endif

@@ sv/frpl_pkg.sv @@
package frpl_pkg;

   // Field widths
   localparam int SAMPLE_W = 10;
   localparam int REG_W    = 18;
   localparam int TIME_W   = 32;
   localparam int PULSE_W  = 16;
   localparam int SUM_W    = 24;
   localparam int CNT_W    = 16;
   localparam int IDX_W    = 5;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W = 1;

   // Padded stream widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 128;

   // Input kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_PULSE = 1'b1;

   // Run phases
   localparam logic [PHASE_W-1:0] PHASE_WAITING = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_RUNNING = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_ENDED   = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_PERIOD = 1'd1;

   // Register reset values
   localparam logic [REG_W-1:0] ITER_PERIOD_RESET = 18'd1000;
   localparam logic [REG_W-1:0] READ_PERIOD_RESET = 18'd100;

   // Record index ceiling
   localparam logic [IDX_W-1:0] IDX_MAX = 5'd31;

   typedef struct packed {
      logic                 we;
      logic [CSR_IDX_W-1:0] index;
      logic [REG_W-1:0]     wdata;
   } csr_wr_type;

   typedef struct packed {
      logic [IDX_W-1:0]   record_index;
      logic [PULSE_W-1:0] pulse_count;
      logic [SUM_W-1:0]   current_sum;
      logic [CNT_W-1:0]   read_count;
      logic [TIME_W-1:0]  end_time_ms;
      logic [PHASE_W-1:0] phase;
      logic [TIME_W-1:0]  start_time_ms;
      logic               finished;
   } rec_type;

   typedef struct packed {
      logic               halted;
      logic [PHASE_W-1:0] phase;
   } status_type;

endpackage

@@ sv/frpl_rsp_buf.sv @@
module frpl_rsp_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  frpl_pkg::rec_type in_rec,
   output logic             can_take,
   output logic             out_valid,
   output frpl_pkg::rec_type out_rec,
   input  logic             out_ready
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   frpl_pkg::rec_type main_rec_ff, main_rec_in;
   frpl_pkg::rec_type skid_rec_ff, skid_rec_in;

   assign can_take  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_rec   = main_rec_ff;

   // Refill the output register from the skid stage first, else hold into skid
   always_comb begin
      main_valid_in = main_valid_ff;
      main_rec_in   = main_rec_ff;
      skid_valid_in = skid_valid_ff;
      skid_rec_in   = skid_rec_ff;
      if (!main_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_rec_in   = skid_rec_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_rec_in   = in_rec;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_rec_in   = in_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_rec_ff <= main_rec_in;
      skid_rec_ff <= skid_rec_in;
   end

endmodule

@@ sv/frpl_core.sv @@
module frpl_core #(
   parameter int MAX_RECORDS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_kind,
   input  logic [frpl_pkg::SAMPLE_W-1:0]     req_sample,
   input  frpl_pkg::csr_wr_type              csr,
   input  logic                              can_take,
   output logic                              res_valid,
   output frpl_pkg::rec_type                 res_rec,
   output frpl_pkg::status_type              status
);

   localparam logic [frpl_pkg::IDX_W-1:0] REC_LIMIT = frpl_pkg::IDX_W'(MAX_RECORDS);

   // Input register
   logic                          in_valid_ff, in_valid_in;
   logic                          in_kind_ff;
   logic [frpl_pkg::SAMPLE_W-1:0] in_sample_ff;

   // Configuration
   logic [frpl_pkg::REG_W-1:0] iter_period_ff, iter_period_in;
   logic [frpl_pkg::REG_W-1:0] read_period_ff, read_period_in;

   // Block state
   logic [frpl_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [frpl_pkg::TIME_W-1:0]  period_start_ff, period_start_in;
   logic [frpl_pkg::TIME_W-1:0]  last_read_ff, last_read_in;
   logic [frpl_pkg::PULSE_W-1:0] pulse_acc_ff, pulse_acc_in;
   logic [frpl_pkg::SUM_W-1:0]   sample_acc_ff, sample_acc_in;
   logic [frpl_pkg::CNT_W-1:0]   sample_cnt_ff, sample_cnt_in;
   logic [frpl_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [frpl_pkg::IDX_W-1:0]   rec_idx_ff, rec_idx_in;
   logic [frpl_pkg::TIME_W-1:0]  run_start_ff, run_start_in;
   logic                         halted_ff, halted_in;

   logic                         fire;
   logic                         accept;
   logic [frpl_pkg::TIME_W-1:0]  now_next;
   logic [frpl_pkg::TIME_W-1:0]  since_read;
   logic [frpl_pkg::TIME_W-1:0]  since_period;
   logic                         read_due;
   logic                         close_due;
   logic [frpl_pkg::SUM_W:0]     sum_wide;
   logic [frpl_pkg::SUM_W-1:0]   sum_read;
   logic [frpl_pkg::CNT_W-1:0]   cnt_read;

   assign fire      = in_valid_ff && can_take;
   assign req_ready = !in_valid_ff || can_take;
   assign accept    = req_valid && req_ready;
   assign status    = '{halted: halted_ff, phase: phase_ff};

   // Advance the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Take configuration writes
   always_comb begin
      iter_period_in = iter_period_ff;
      read_period_in = read_period_ff;
      if (csr.we) begin
         case (csr.index)
            frpl_pkg::CSR_ITER_PERIOD: iter_period_in = csr.wdata;
            frpl_pkg::CSR_READ_PERIOD: read_period_in = csr.wdata;
            default: ;
         endcase
      end
   end

   // Time differences and the sample read of a tick
   assign now_next     = now_ff + frpl_pkg::TIME_W'(1);
   assign since_read   = now_next - last_read_ff;
   assign since_period = now_next - period_start_ff;
   assign read_due     = since_read >= frpl_pkg::TIME_W'(read_period_ff);
   assign close_due    = since_period >= frpl_pkg::TIME_W'(iter_period_ff);
   assign sum_wide     = {1'b0, sample_acc_ff} + (frpl_pkg::SUM_W+1)'(in_sample_ff);

   always_comb begin
      sum_read = sample_acc_ff;
      cnt_read = sample_cnt_ff;
      if (read_due) begin
         sum_read = sum_wide[frpl_pkg::SUM_W] ? '1 : sum_wide[frpl_pkg::SUM_W-1:0];
         cnt_read = (sample_cnt_ff == '1) ? sample_cnt_ff
                                          : sample_cnt_ff + frpl_pkg::CNT_W'(1);
      end
   end

   // Update state for one request and build the record of a closing tick
   always_comb begin
      now_in          = now_ff;
      period_start_in = period_start_ff;
      last_read_in    = last_read_ff;
      pulse_acc_in    = pulse_acc_ff;
      sample_acc_in   = sample_acc_ff;
      sample_cnt_in   = sample_cnt_ff;
      phase_in        = phase_ff;
      rec_idx_in      = rec_idx_ff;
      run_start_in    = run_start_ff;
      halted_in       = halted_ff;
      res_valid       = 1'b0;
      res_rec         = '0;
      if (fire && !halted_ff) begin
         if (in_kind_ff == frpl_pkg::KIND_PULSE) begin
            if (pulse_acc_ff != '1) begin
               pulse_acc_in = pulse_acc_ff + frpl_pkg::PULSE_W'(1);
            end
         end else begin
            now_in        = now_next;
            sample_acc_in = sum_read;
            sample_cnt_in = cnt_read;
            if (read_due) begin
               last_read_in = now_next;
            end
            if (close_due) begin
               // Step the run detector on this period's pulse count
               if (pulse_acc_ff == '0 && phase_ff == frpl_pkg::PHASE_RUNNING) begin
                  phase_in = frpl_pkg::PHASE_ENDED;
               end else if (pulse_acc_ff != '0 && phase_ff == frpl_pkg::PHASE_WAITING) begin
                  phase_in     = frpl_pkg::PHASE_RUNNING;
                  run_start_in = now_next;
               end
               if (phase_in == frpl_pkg::PHASE_RUNNING && rec_idx_ff < frpl_pkg::IDX_MAX) begin
                  rec_idx_in = rec_idx_ff + frpl_pkg::IDX_W'(1);
               end
               halted_in       = (phase_in == frpl_pkg::PHASE_ENDED) || (rec_idx_in >= REC_LIMIT);
               period_start_in = now_next;
               pulse_acc_in    = '0;
               sample_acc_in   = '0;
               sample_cnt_in   = '0;
               res_valid       = 1'b1;
               res_rec.record_index  = rec_idx_ff;
               res_rec.pulse_count   = pulse_acc_ff;
               res_rec.current_sum   = sum_read;
               res_rec.read_count    = cnt_read;
               res_rec.end_time_ms   = now_next;
               res_rec.phase         = phase_in;
               res_rec.start_time_ms = run_start_in;
               res_rec.finished      = halted_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         iter_period_ff  <= frpl_pkg::ITER_PERIOD_RESET;
         read_period_ff  <= frpl_pkg::READ_PERIOD_RESET;
         now_ff          <= '0;
         period_start_ff <= '0;
         last_read_ff    <= '0;
         pulse_acc_ff    <= '0;
         sample_acc_ff   <= '0;
         sample_cnt_ff   <= '0;
         phase_ff        <= frpl_pkg::PHASE_WAITING;
         rec_idx_ff      <= '0;
         run_start_ff    <= '0;
         halted_ff       <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         iter_period_ff  <= iter_period_in;
         read_period_ff  <= read_period_in;
         now_ff          <= now_in;
         period_start_ff <= period_start_in;
         last_read_ff    <= last_read_in;
         pulse_acc_ff    <= pulse_acc_in;
         sample_acc_ff   <= sample_acc_in;
         sample_cnt_ff   <= sample_cnt_in;
         phase_ff        <= phase_in;
         rec_idx_ff      <= rec_idx_in;
         run_start_ff    <= run_start_in;
         halted_ff       <= halted_in;
      end
      if (accept) begin
         in_kind_ff   <= req_kind;
         in_sample_ff <= req_sample;
      end
   end

endmodule

@@ sv/flow_run_period_logger.sv @@
// Flow run period logger.
// Requests arrive on the req_ stream: req_tuser is the kind (0 millisecond tick,
// 1 flow pulse) and req_tdata carries the current sample on ticks. Each tick
// advances the millisecond clock, takes a sample when the read period is due and
// closes a period when the iteration period is due; a closing tick yields one
// record on the rsp_ stream, with rsp_tlast set when the block stops after it.
// Periods are set through the csr_ write port; the user must write them only
// while the block is idle, which the block itself does not enforce. A tick is
// accepted into the input register, and its record is then loaded into the output
// register, or into the skid stage while the receiver stalls. The block takes one
// request per cycle while the skid stage is free.
// Reset clears all state, sets the periods to 1000 ms and 100 ms and empties
// the pipeline. When the receiver stalls, the output register and a skid stage
// hold two records; req_tready then drops while the input register is occupied,
// until rsp_tready frees a slot.
// After the stopping record, further requests are taken and ignored.
`include "flow_run_period_logger_assert.svh"

module flow_run_period_logger #(
   parameter int MAX_RECORDS = 20
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // fields: current_sample[9:0], zero padding above
   input  logic [frpl_pkg::REQ_DATA_W-1:0]      req_tdata,
   // fields: kind[0]
   input  logic                                 req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // fields: record_index[4:0], pulse_count[20:5], current_sum[44:21],
   // read_count[60:45], end_time_ms[92:61], phase[94:93],
   // start_time_ms[126:95], zero padding above
   output logic [frpl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // fields: finished
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [frpl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [frpl_pkg::REG_W-1:0]           csr_wdata
);

   frpl_pkg::csr_wr_type csr;
   frpl_pkg::rec_type    res_rec;
   frpl_pkg::rec_type    out_rec;
   frpl_pkg::status_type status;
   logic                 res_valid;
   logic                 can_take;

   assign csr = '{we: csr_we, index: csr_index, wdata: csr_wdata};

   frpl_core #(
      .MAX_RECORDS(MAX_RECORDS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_sample (req_tdata[frpl_pkg::SAMPLE_W-1:0]),
      .csr        (csr),
      .can_take   (can_take),
      .res_valid  (res_valid),
      .res_rec    (res_rec),
      .status     (status)
   );

   frpl_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_rec    (res_rec),
      .can_take  (can_take),
      .out_valid (rsp_tvalid),
      .out_rec   (out_rec),
      .out_ready (rsp_tready)
   );

   // Pack the record, first field lowest
   assign rsp_tdata = {1'b0, out_rec.start_time_ms, out_rec.phase, out_rec.end_time_ms,
                       out_rec.read_count, out_rec.current_sum, out_rec.pulse_count,
                       out_rec.record_index};
   assign rsp_tlast = out_rec.finished;

   // Requests stall only while a record waits at the output
   `FRPL_ASSERT_SAME(a_stall_needs_rsp, clock, reset, !req_tready, rsp_tvalid)
   // No record comes out of a halted block
   `FRPL_ASSERT_SAME(a_no_rec_halted, clock, reset, res_valid, !status.halted)
   // Halt holds until reset
   `FRPL_ASSERT_NEXT(a_halt_sticky, clock, reset, status.halted, status.halted)
   // A record that stops the block carries the ended phase or a running one
   `FRPL_ASSERT_SAME(a_fin_phase, clock, reset, res_valid && res_rec.finished,
                     res_rec.phase == frpl_pkg::PHASE_ENDED ||
                     res_rec.phase == frpl_pkg::PHASE_RUNNING)

endmodule

@@ test/tb_flow_run_period_logger.sv @@
module tb_flow_run_period_logger;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_RECORDS    = 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_TICKS   = 700;
   localparam int FIELD_W        = frpl_pkg::TIME_W;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic                          kind;
      logic [frpl_pkg::SAMPLE_W-1:0] sample;
   } flow_req_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic [frpl_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                            req_tuser  = frpl_pkg::KIND_TICK;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [frpl_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            csr_we     = 1'b0;
   logic [frpl_pkg::CSR_IDX_W-1:0]  csr_index  = frpl_pkg::CSR_ITER_PERIOD;
   logic [frpl_pkg::REG_W-1:0]      csr_wdata  = '0;

   flow_req_type      queued_requests[$];
   frpl_pkg::rec_type expected_records[$];
   idle_mode_type     idle_mode = IDLE_NONE;
   int                mismatch_count = 0;
   int                quiet_cycles = 0;

   // Logger state as the block should hold it
   logic [frpl_pkg::REG_W-1:0]   cfg_iter_ms   = frpl_pkg::ITER_PERIOD_RESET;
   logic [frpl_pkg::REG_W-1:0]   cfg_read_ms   = frpl_pkg::READ_PERIOD_RESET;
   logic [frpl_pkg::TIME_W-1:0]  ms_now        = '0;
   logic [frpl_pkg::TIME_W-1:0]  boundary_ms   = '0;
   logic [frpl_pkg::TIME_W-1:0]  last_read_ms  = '0;
   logic [frpl_pkg::PULSE_W-1:0] period_pulses = '0;
   logic [frpl_pkg::SUM_W-1:0]   period_sum    = '0;
   logic [frpl_pkg::CNT_W-1:0]   period_reads  = '0;
   logic [frpl_pkg::PHASE_W-1:0] run_state     = frpl_pkg::PHASE_WAITING;
   logic [frpl_pkg::IDX_W-1:0]   record_idx    = '0;
   logic [frpl_pkg::TIME_W-1:0]  run_began_ms  = '0;
   logic                         stopped       = 1'b0;

   always #4 clock = ~clock;

   flow_run_period_logger #(
      .MAX_RECORDS(MAX_RECORDS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Advance the logger state by one request and queue the record it closes
   function automatic void log_request(flow_req_type r);
      logic [frpl_pkg::SUM_W:0]     sum;
      logic [frpl_pkg::PULSE_W-1:0] pulses;
      logic [frpl_pkg::TIME_W-1:0]  since_read;
      logic [frpl_pkg::TIME_W-1:0]  since_boundary;
      frpl_pkg::rec_type            rec;
      if (stopped) return;
      if (r.kind == frpl_pkg::KIND_PULSE) begin
         if (period_pulses != '1) period_pulses = period_pulses + frpl_pkg::PULSE_W'(1);
         return;
      end
      ms_now = ms_now + frpl_pkg::TIME_W'(1);
      // sample first, so a read on the closing tick counts in that period
      since_read = ms_now - last_read_ms;
      if (since_read >= frpl_pkg::TIME_W'(cfg_read_ms)) begin
         sum = {1'b0, period_sum} + (frpl_pkg::SUM_W+1)'(r.sample);
         period_sum = sum[frpl_pkg::SUM_W] ? '1 : sum[frpl_pkg::SUM_W-1:0];
         if (period_reads != '1) period_reads = period_reads + frpl_pkg::CNT_W'(1);
         last_read_ms = ms_now;
      end
      since_boundary = ms_now - boundary_ms;
      if (since_boundary >= frpl_pkg::TIME_W'(cfg_iter_ms)) begin
         pulses = period_pulses;
         period_pulses = '0;
         if (pulses == '0 && run_state == frpl_pkg::PHASE_RUNNING) begin
            run_state = frpl_pkg::PHASE_ENDED;
         end else if (pulses != '0 && run_state == frpl_pkg::PHASE_WAITING) begin
            run_state = frpl_pkg::PHASE_RUNNING;
            run_began_ms = ms_now;
         end
         boundary_ms = ms_now;
         rec.record_index  = record_idx;
         rec.pulse_count   = pulses;
         rec.current_sum   = period_sum;
         rec.read_count    = period_reads;
         rec.end_time_ms   = ms_now;
         rec.phase         = run_state;
         rec.start_time_ms = run_began_ms;
         period_sum   = '0;
         period_reads = '0;
         if (run_state == frpl_pkg::PHASE_RUNNING && record_idx != frpl_pkg::IDX_MAX)
            record_idx = record_idx + frpl_pkg::IDX_W'(1);
         stopped = (run_state == frpl_pkg::PHASE_ENDED) ||
                   (record_idx >= frpl_pkg::IDX_W'(MAX_RECORDS));
         rec.finished = stopped;
         expected_records.push_back(rec);
      end
   endfunction

   function automatic logic go_now(int idle_pct);
      return $urandom_range(0, 99) >= idle_pct;
   endfunction

   function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                       logic [FIELD_W-1:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: record field %s mismatch: expected %0d, got %0d",
                     $realtime, name, want, got);
      end
   endfunction

   // Request driver: hold the request until taken, then load the next one
   always @(posedge clock) begin
      flow_req_type nxt;
      int           idle_pct;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            log_request('{kind: req_tuser, sample: req_tdata[frpl_pkg::SAMPLE_W-1:0]});
         if (!req_tvalid || req_tready) begin
            idle_pct = (idle_mode == IDLE_SENDER) ? 86 : (idle_mode == IDLE_BOTH) ? 13 : 0;
            if (queued_requests.size() != 0 && go_now(idle_pct)) begin
               nxt = queued_requests.pop_front();
               req_tuser  <= nxt.kind;
               req_tdata  <= frpl_pkg::REQ_DATA_W'(nxt.sample);
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Record monitor: compare each accepted record with the oldest expected one
   always @(posedge clock) begin
      frpl_pkg::rec_type got;
      frpl_pkg::rec_type want;
      int                idle_pct;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.record_index  = rsp_tdata[4:0];
            got.pulse_count   = rsp_tdata[20:5];
            got.current_sum   = rsp_tdata[44:21];
            got.read_count    = rsp_tdata[60:45];
            got.end_time_ms   = rsp_tdata[92:61];
            got.phase         = rsp_tdata[94:93];
            got.start_time_ms = rsp_tdata[126:95];
            got.finished      = rsp_tlast;
            if (expected_records.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected record, index %0d end time %0d",
                           $realtime, got.record_index, got.end_time_ms);
            end else begin
               want = expected_records.pop_front();
               check_field("record_index", FIELD_W'(want.record_index),
                           FIELD_W'(got.record_index));
               check_field("pulse_count", FIELD_W'(want.pulse_count),
                           FIELD_W'(got.pulse_count));
               check_field("current_sum", FIELD_W'(want.current_sum),
                           FIELD_W'(got.current_sum));
               check_field("read_count", FIELD_W'(want.read_count),
                           FIELD_W'(got.read_count));
               check_field("end_time_ms", want.end_time_ms, got.end_time_ms);
               check_field("phase", FIELD_W'(want.phase), FIELD_W'(got.phase));
               check_field("start_time_ms", want.start_time_ms, got.start_time_ms);
               check_field("finished", FIELD_W'(want.finished), FIELD_W'(got.finished));
            end
         end
         idle_pct = (idle_mode == IDLE_RECEIVER) ? 86 : (idle_mode == IDLE_BOTH) ? 13 : 0;
         rsp_tready <= go_now(idle_pct);
      end
   end

   // Watchdog: stop when nothing moves for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic void push_request(logic kind, logic [frpl_pkg::SAMPLE_W-1:0] sample);
      queued_requests.push_back('{kind: kind, sample: sample});
   endfunction

   function automatic logic [frpl_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return frpl_pkg::SAMPLE_W'($urandom());
      endcase
   endfunction

   // Ticks still needed to close the current period
   function automatic int ticks_to_close();
      logic [frpl_pkg::TIME_W-1:0] gap;
      gap = ms_now - boundary_ms;
      if (gap >= frpl_pkg::TIME_W'(cfg_iter_ms)) return 1;
      return int'(frpl_pkg::TIME_W'(cfg_iter_ms) - gap);
   endfunction

   // One period of the given length, pulses spread before the closing tick
   function automatic void push_period(int ticks, int pulses);
      int left;
      int k;
      left = pulses;
      for (int i = 0; i < ticks; i++) begin
         k = (i == ticks - 1) ? left : $urandom_range(0, (left > 2) ? 2 : left);
         repeat (k) push_request(frpl_pkg::KIND_PULSE, frpl_pkg::SAMPLE_W'($urandom()));
         left -= k;
         push_request(frpl_pkg::KIND_TICK, pick_sample());
      end
   endfunction

   // Wait until every request is taken, every record is back and the pipe is empty
   task automatic settle();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_tvalid || expected_records.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [frpl_pkg::CSR_IDX_W-1:0] idx,
                            logic [frpl_pkg::REG_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == frpl_pkg::CSR_ITER_PERIOD) cfg_iter_ms = value;
      else cfg_read_ms = value;
   endtask

   initial begin
      int                         issued;
      int                         phase_no;
      int                         n;
      int                         periods;
      logic                       by_limit;
      logic [frpl_pkg::REG_W-1:0] iter_val;
      logic [frpl_pkg::REG_W-1:0] read_val;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset periods: reads accumulate with alternating extreme samples
      for (int i = 0; i < 200; i++)
         push_request(frpl_pkg::KIND_TICK, i[0] ? 10'h3FF : 10'h000);
      settle();

      // Zero periods: a read and a record on every tick
      write_reg(frpl_pkg::CSR_ITER_PERIOD, '0);
      write_reg(frpl_pkg::CSR_READ_PERIOD, '0);
      push_request(frpl_pkg::KIND_TICK, 10'h000);
      push_request(frpl_pkg::KIND_TICK, 10'h3FF);
      push_request(frpl_pkg::KIND_TICK, 10'h155);
      push_request(frpl_pkg::KIND_TICK, 10'h2AA);
      push_request(frpl_pkg::KIND_TICK, 10'h001);
      push_request(frpl_pkg::KIND_TICK, 10'h200);
      settle();

      // Shortest nonzero iteration period, long read period
      write_reg(frpl_pkg::CSR_ITER_PERIOD, 18'd1);
      write_reg(frpl_pkg::CSR_READ_PERIOD, 18'd255000);
      repeat (4) push_request(frpl_pkg::KIND_TICK, pick_sample());
      settle();

      // Long iteration period: nothing closes yet
      write_reg(frpl_pkg::CSR_ITER_PERIOD, 18'd255000);
      write_reg(frpl_pkg::CSR_READ_PERIOD, 18'd1);
      repeat (30) push_request(frpl_pkg::KIND_TICK, pick_sample());
      settle();

      // Random waiting periods over many settings and idling patterns
      issued = 0;
      phase_no = 0;
      while (issued < RANDOM_TICKS) begin
         case ($urandom_range(0, 9))
            0:       iter_val = '0;
            1:       iter_val = 18'd255000;
            default: iter_val = frpl_pkg::REG_W'($urandom_range(1, 30));
         endcase
         case ($urandom_range(0, 7))
            0:       read_val = '0;
            1:       read_val = 18'd255000;
            default: read_val = frpl_pkg::REG_W'($urandom_range(1, 40));
         endcase
         if ($urandom_range(0, 3) != 0) write_reg(frpl_pkg::CSR_ITER_PERIOD, iter_val);
         if ($urandom_range(0, 3) != 0) write_reg(frpl_pkg::CSR_READ_PERIOD, read_val);
         idle_mode = idle_mode_type'(phase_no % 4);
         n = $urandom_range(30, 90);
         repeat (n) push_request(frpl_pkg::KIND_TICK, pick_sample());
         issued += n;
         phase_no++;
         settle();
      end

      // Start the run with a few pulses in one period
      idle_mode = IDLE_NONE;
      write_reg(frpl_pkg::CSR_ITER_PERIOD, frpl_pkg::REG_W'($urandom_range(3, 10)));
      write_reg(frpl_pkg::CSR_READ_PERIOD, frpl_pkg::REG_W'($urandom_range(0, 5)));
      n = ticks_to_close();
      repeat ($urandom_range(1, 8))
         push_request(frpl_pkg::KIND_PULSE, frpl_pkg::SAMPLE_W'($urandom()));
      repeat (n) push_request(frpl_pkg::KIND_TICK, pick_sample());

      // Running periods, ended either by the record limit or by a quiet period
      by_limit = $urandom_range(0, 1);
      periods = by_limit ? MAX_RECORDS - 1 : $urandom_range(2, 12);
      for (int p = 0; p < periods; p++) begin
         while (queued_requests.size() != 0) @(negedge clock);
         idle_mode = idle_mode_type'($urandom_range(0, 3));
         push_period(int'(cfg_iter_ms), $urandom_range(1, 6));
      end
      if (!by_limit) push_period(int'(cfg_iter_ms), 0);

      // Stopped: these must all be dropped
      repeat (100)
         push_request(logic'($urandom_range(0, 1)), frpl_pkg::SAMPLE_W'($urandom()));
      settle();

      if (mismatch_count == 0 && expected_records.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
